FILE: sv/ssrp_pkg.sv
// shared types and constants for the spi slave register port
`default_nettype none

package ssrp_pkg;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 16;
    localparam int BANK_SIZE = 1 << ADDR_BITS;
    localparam int CMD_BITS  = 8;
    localparam int XFER_END  = CMD_BITS + DATA_BITS;
    localparam int CNT_W     = $clog2(XFER_END + 1);

    localparam logic [CNT_W-1:0] CNT_CMD_END  = CNT_W'(CMD_BITS);
    localparam logic [CNT_W-1:0] CNT_XFER_END = CNT_W'(XFER_END);
    localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);

    // item actions
    localparam logic [1:0] ACT_PIN  = 2'd0;
    localparam logic [1:0] ACT_HWR  = 2'd1;
    localparam logic [1:0] ACT_HRD  = 2'd2;

    // clock modes that sample on the rising edge
    localparam logic [1:0] MODE_0 = 2'd0;
    localparam logic [1:0] MODE_3 = 2'd3;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [DATA_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } t_bank_req;

    typedef struct packed {
        logic                 data_out;
        logic [ADDR_BITS-1:0] cmd_addr;
        logic                 wr_stb;
        logic                 rd_stb;
        logic                 host_sel;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/ssrp_bank.sv
// register bank: 32 x 16 memory with registered read and per-entry valid bits
`default_nettype none

module ssrp_bank (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ssrp_pkg::t_bank_req           i_req,
    output logic [ssrp_pkg::DATA_BITS-1:0]     o_rdata
);

    logic [ssrp_pkg::DATA_BITS-1:0] r_mem [ssrp_pkg::BANK_SIZE];
    logic [ssrp_pkg::BANK_SIZE-1:0] r_valid;
    logic [ssrp_pkg::DATA_BITS-1:0] r_q;
    logic                           r_q_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_ok  <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_q_ok <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_q_ok ? r_q : '0;

endmodule

`default_nettype wire

FILE: sv/ssrp_engine.sv
// spi transfer engine: edge detection, command and data shifting, bank requests
`default_nettype none

module ssrp_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_wdata,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_action,
    input  wire logic                          i_chip_select_n,
    input  wire logic                          i_serial_clock,
    input  wire logic                          i_data_in,
    input  wire logic [4:0]                    i_host_address,
    input  wire logic [15:0]                   i_host_write_data,
    input  wire logic [ssrp_pkg::DATA_BITS-1:0] i_bank_rdata,
    output ssrp_pkg::t_bank_req                o_bank_req,
    output ssrp_pkg::t_result                  o_result
);

    logic [1:0]                       r_mode;
    logic                             r_last_clk, n_last_clk;
    logic [ssrp_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [ssrp_pkg::CMD_BITS-1:0]    r_cmd, n_cmd;
    logic [ssrp_pkg::DATA_BITS-1:0]   r_ws, n_ws;
    logic [ssrp_pkg::DATA_BITS-1:0]   r_rs, n_rs;
    logic                             r_rs_pend, n_rs_pend;
    logic                             r_read_cmd, n_read_cmd;
    logic                             r_out_bit, n_out_bit;

    logic [ssrp_pkg::DATA_BITS-1:0]   rs_cur;
    logic [ssrp_pkg::CMD_BITS-1:0]    cmd_shift;
    logic [ssrp_pkg::DATA_BITS-1:0]   ws_shift;
    logic                             rise, fall, sample_rise, sample_edge, shift_edge;
    logic                             wr_stb, rd_stb;
    ssrp_pkg::t_bank_req              req;

    // the bank word for a finished command comes from the bank read register
    assign rs_cur = r_rs_pend ? i_bank_rdata : r_rs;

    assign rise        = !r_last_clk && i_serial_clock;
    assign fall        = r_last_clk && !i_serial_clock;
    assign sample_rise = (r_mode == ssrp_pkg::MODE_0) || (r_mode == ssrp_pkg::MODE_3);
    assign sample_edge = sample_rise ? rise : fall;
    assign shift_edge  = sample_rise ? fall : rise;
    assign cmd_shift   = {r_cmd[ssrp_pkg::CMD_BITS-2:0], i_data_in};
    assign ws_shift    = {r_ws[ssrp_pkg::DATA_BITS-2:0], i_data_in};

    always_comb begin
        n_last_clk = r_last_clk;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_ws       = r_ws;
        n_rs       = rs_cur;
        n_rs_pend  = 1'b0;
        n_read_cmd = r_read_cmd;
        n_out_bit  = r_out_bit;
        wr_stb     = 1'b0;
        rd_stb     = 1'b0;
        req        = '0;
        case (i_action)
            ssrp_pkg::ACT_PIN: begin
                n_last_clk = i_serial_clock;
                if (i_chip_select_n) begin
                    n_cnt      = '0;
                    n_cmd      = '0;
                    n_ws       = '0;
                    n_rs       = '0;
                    n_read_cmd = 1'b0;
                    n_out_bit  = 1'b0;
                end else begin
                    if (sample_edge) begin
                        if (r_cnt < ssrp_pkg::CNT_CMD_END) begin
                            n_cmd = cmd_shift;
                            n_cnt = r_cnt + ssrp_pkg::CNT_ONE;
                            if (n_cnt == ssrp_pkg::CNT_CMD_END) begin
                                n_read_cmd = !cmd_shift[ssrp_pkg::CMD_BITS-1];
                                n_cmd      = ssrp_pkg::CMD_BITS'(
                                                 cmd_shift[ssrp_pkg::ADDR_BITS-1:0]);
                                req.re     = 1'b1;
                                req.raddr  = cmd_shift[ssrp_pkg::ADDR_BITS-1:0];
                                n_rs_pend  = 1'b1;
                                rd_stb     = !cmd_shift[ssrp_pkg::CMD_BITS-1];
                            end
                        end else if (!r_read_cmd && r_cnt < ssrp_pkg::CNT_XFER_END) begin
                            n_ws  = ws_shift;
                            n_cnt = r_cnt + ssrp_pkg::CNT_ONE;
                            if (n_cnt == ssrp_pkg::CNT_XFER_END) begin
                                req.we    = 1'b1;
                                req.waddr = r_cmd[ssrp_pkg::ADDR_BITS-1:0];
                                req.wdata = ws_shift;
                                wr_stb    = 1'b1;
                            end
                        end
                    end
                    // sample and shift edges never coincide
                    if (shift_edge && r_read_cmd && r_cnt >= ssrp_pkg::CNT_CMD_END
                            && r_cnt < ssrp_pkg::CNT_XFER_END) begin
                        n_out_bit = rs_cur[ssrp_pkg::DATA_BITS-1];
                        n_rs      = {rs_cur[ssrp_pkg::DATA_BITS-2:0], 1'b0};
                        n_cnt     = r_cnt + ssrp_pkg::CNT_ONE;
                    end
                end
            end
            ssrp_pkg::ACT_HWR: begin
                req.we    = 1'b1;
                req.waddr = i_host_address[ssrp_pkg::ADDR_BITS-1:0];
                req.wdata = ssrp_pkg::DATA_BITS'(i_host_write_data);
            end
            ssrp_pkg::ACT_HRD: begin
                req.re    = 1'b1;
                req.raddr = i_host_address[ssrp_pkg::ADDR_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_last_clk <= 1'b0;
            r_cnt      <= '0;
            r_cmd      <= '0;
            r_ws       <= '0;
            r_rs       <= '0;
            r_rs_pend  <= 1'b0;
            r_read_cmd <= 1'b0;
            r_out_bit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_last_clk <= n_last_clk;
                r_cnt      <= n_cnt;
                r_cmd      <= n_cmd;
                r_ws       <= n_ws;
                r_rs       <= n_rs;
                r_rs_pend  <= n_rs_pend;
                r_read_cmd <= n_read_cmd;
                r_out_bit  <= n_out_bit;
            end
        end
    end

    always_comb begin
        o_bank_req    = req;
        o_bank_req.we = req.we && i_accept;
        o_bank_req.re = req.re && i_accept;
    end

    always_comb begin
        o_result          = '0;
        o_result.data_out = n_out_bit;
        o_result.cmd_addr = n_cmd[ssrp_pkg::ADDR_BITS-1:0];
        o_result.wr_stb   = wr_stb;
        o_result.rd_stb   = rd_stb;
        o_result.host_sel = (i_action == ssrp_pkg::ACT_HRD);
    end

endmodule

`default_nettype wire

FILE: sv/spi_slave_register_port.sv
// top level of the spi slave register port
`default_nettype none

// SPI slave with a bank of 32 sixteen-bit registers, driven by oversampled pin
// levels and by direct host reads and writes. One item is accepted every clock
// cycle while o_in_stall is low; each item gives one result beat from the output
// register in the following cycle; a new item is taken while that beat waits
// as long as the receiver is not stalling. The bank is a synchronous memory with a
// registered read, so host read data and the word loaded at the end of a read
// command both come from the read register. Entries start at zero after reset,
// without a clearing pass. clock_mode is written through i_cfg_we / i_cfg_wdata
// and applies from the next pin sample.
module spi_slave_register_port (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic        i_chip_select_n,
    input  wire logic        i_serial_clock,
    input  wire logic        i_data_in,
    input  wire logic [4:0]  i_host_address,
    input  wire logic [15:0] i_host_write_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_data_out,
    output logic [4:0]       o_register_address,
    output logic             o_write_strobe,
    output logic             o_read_strobe,
    output logic [15:0]      o_host_read_data
);

    logic                           accept;
    ssrp_pkg::t_bank_req            bank_req;
    ssrp_pkg::t_result              result;
    logic [ssrp_pkg::DATA_BITS-1:0] bank_rdata;
    logic                           r_out_valid;
    ssrp_pkg::t_result              r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    ssrp_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_accept          (accept),
        .i_action          (i_action),
        .i_chip_select_n   (i_chip_select_n),
        .i_serial_clock    (i_serial_clock),
        .i_data_in         (i_data_in),
        .i_host_address    (i_host_address),
        .i_host_write_data (i_host_write_data),
        .i_bank_rdata      (bank_rdata),
        .o_bank_req        (bank_req),
        .o_result          (result)
    );

    ssrp_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .o_rdata (bank_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    // the read register only moves on an accepted beat, so it holds under stall
    assign o_out_valid        = r_out_valid;
    assign o_data_out         = r_out.data_out;
    assign o_register_address = 5'(r_out.cmd_addr);
    assign o_write_strobe     = r_out.wr_stb;
    assign o_read_strobe      = r_out.rd_stb;
    assign o_host_read_data   = r_out.host_sel ? 16'(bank_rdata) : 16'd0;

endmodule

`default_nettype wire
